@@ hw/rtl/lisp_token_scanner_unit_macros.svh @@
// Assertion macros shared by the token scanner RTL.
`ifndef LISP_TOKEN_SCANNER_UNIT_MACROS_SVH
`define LISP_TOKEN_SCANNER_UNIT_MACROS_SVH

// Plain property checked every clock outside reset.
`define LTS_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define LTS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/lts_pkg.sv @@
// Shared types, character codes and keyword tables of the token scanner.
package lts_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int TDATA_W     = 144;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_NUMBER  = 2'd1,
    MODE_KEYWORD = 2'd2,
    MODE_IDENT   = 2'd3
  } scan_mode_t;

  typedef enum logic [3:0] {
    TK_ADD     = 4'd0,
    TK_SUB     = 4'd1,
    TK_MUL     = 4'd2,
    TK_DIV     = 4'd3,
    TK_GREATER = 4'd4,
    TK_LESS    = 4'd5,
    TK_NUMBER  = 4'd6,
    TK_SETQ    = 4'd7,
    TK_WHILE   = 4'd8,
    TK_PRINT   = 4'd9,
    TK_DEFUN   = 4'd10,
    TK_LPAREN  = 4'd11,
    TK_RPAREN  = 4'd12,
    TK_IDENT   = 4'd13,
    TK_END     = 4'd14
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [31:0] value;
    logic        ovf;
    logic [7:0]  len;
    logic [63:0] prefix;
    logic [15:0] line;
    logic [15:0] col;
    logic        last;
  } token_t;

  // Front-to-queue write request: up to two tokens per character.
  typedef struct packed {
    logic   push0;
    logic   push1;
    token_t tok0;
    token_t tok1;
  } push_req_t;

  function automatic logic [2:0] kw_len(input logic [1:0] ch);
    logic [2:0] len;
    len = (ch == 2'd0) ? 3'd4 : 3'd5;
    return len;
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] ch, input logic [2:0] pos);
    logic [7:0] r;
    r = 8'h00;
    case ({ch, pos})
      5'b00_000: r = "s";
      5'b00_001: r = "e";
      5'b00_010: r = "t";
      5'b00_011: r = "q";
      5'b01_000: r = "w";
      5'b01_001: r = "h";
      5'b01_010: r = "i";
      5'b01_011: r = "l";
      5'b01_100: r = "e";
      5'b10_000: r = "p";
      5'b10_001: r = "r";
      5'b10_010: r = "i";
      5'b10_011: r = "n";
      5'b10_100: r = "t";
      5'b11_000: r = "d";
      5'b11_001: r = "e";
      5'b11_010: r = "f";
      5'b11_011: r = "u";
      5'b11_100: r = "n";
      default:   r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/lisp_token_scanner_unit.sv @@
// Lisp token scanner: one source character in, zero to two tokens out.
// A closed token enters the token queue, then the output register that drives m_axis.
// Throughput: one character per clock; two tokens from one character leave the output port
// one after the other, and input stalls only when the 4-entry token queue has < 2 free.
// Reset (rst, synchronous): idle scan mode, line and column 1, queue and output empty.
module lisp_token_scanner_unit #(
  parameter int IDENT_LIMIT   = 255,
  parameter int NUMBER_BITS   = 32,
  parameter int POSITION_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // char_code
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // token_kind, number_value, number_overflow, ident_length, ident_prefix,
  // start_line, start_column, zero pad
  output logic [lts_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic                        m_axis_tlast    // last_of_run
);

  lts_pkg::push_req_t push;
  lts_pkg::token_t    head, out_tok;
  logic               space_ok, head_valid, pop;

  lts_front #(
    .IDENT_LIMIT   (IDENT_LIMIT),
    .NUMBER_BITS   (NUMBER_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_char  (s_axis_tdata),
    .space_ok (space_ok),
    .push     (push)
  );

  lts_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .space_ok   (space_ok),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  lts_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_tok    (out_tok)
  );

  assign m_axis_tdata = {3'b000, out_tok.col, out_tok.line, out_tok.prefix, out_tok.len,
                         out_tok.ovf, out_tok.value, out_tok.kind};
  assign m_axis_tlast = out_tok.last;

endmodule

@@ hw/rtl/lts_front.sv @@
// Front end: takes one character per cycle while space_ok, tracks position, emits tokens.
module lts_front #(
  parameter int IDENT_LIMIT   = 255,
  parameter int NUMBER_BITS   = 32,
  parameter int POSITION_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_char,
  input  logic              space_ok,
  output lts_pkg::push_req_t push
);

  localparam logic [NUMBER_BITS-1:0]   NUM_MAX = {NUMBER_BITS{1'b1}};
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

  lts_pkg::scan_mode_t mode, mode_next;
  logic [1:0]  kw_choice, kw_choice_next;
  logic [2:0]  match_pos, match_pos_next;
  logic [NUMBER_BITS-1:0] accum, accum_next;
  logic        sat, sat_next;
  logic [7:0]  id_count, id_count_next;
  logic [63:0] id_chars, id_chars_next;
  logic [POSITION_BITS-1:0] line_count, line_count_next;
  logic [POSITION_BITS-1:0] col_count, col_count_next;
  logic [POSITION_BITS-1:0] tok_line, tok_line_next;
  logic [POSITION_BITS-1:0] tok_col, tok_col_next;

  logic        accept;
  logic [7:0]  c;
  logic        c_space, c_nul, c_digit, c_lp, c_rp, op_hit, kw_start, c_start, id_term;
  lts_pkg::tok_kind_t op_kind, kw_kind;
  logic [1:0]  kw_idx;
  logic        kw_hit, kw_done, rescan, do_append;
  lts_pkg::scan_mode_t idle_mode;
  logic [3:0]  digit;
  logic [NUMBER_BITS+3:0] prod;
  logic        pre_v, idle_v;
  lts_pkg::token_t pre_tok, idle_tok;

  assign c        = in_char;
  assign in_ready = space_ok;
  assign accept   = in_valid && space_ok;

  // character classes
  always_comb begin
    c_space = (c == lts_pkg::CH_SP) || (c == lts_pkg::CH_TAB) ||
              (c == lts_pkg::CH_BS) || (c == lts_pkg::CH_NL);
    c_nul   = (c == lts_pkg::CH_NUL);
    c_digit = (c > lts_pkg::CH_SLASH) && (c < lts_pkg::CH_COLON);
    c_lp    = (c == lts_pkg::CH_LPAR);
    c_rp    = (c == lts_pkg::CH_RPAR);
    op_hit  = 1'b1;
    op_kind = lts_pkg::TK_ADD;
    unique case (c)
      lts_pkg::CH_PLUS:  op_kind = lts_pkg::TK_ADD;
      lts_pkg::CH_MINUS: op_kind = lts_pkg::TK_SUB;
      lts_pkg::CH_STAR:  op_kind = lts_pkg::TK_MUL;
      lts_pkg::CH_SLASH: op_kind = lts_pkg::TK_DIV;
      lts_pkg::CH_GT:    op_kind = lts_pkg::TK_GREATER;
      lts_pkg::CH_LT:    op_kind = lts_pkg::TK_LESS;
      default:           op_hit  = 1'b0;
    endcase
    kw_start = 1'b1;
    kw_idx   = 2'd0;
    unique case (c)
      8'h73:   kw_idx   = 2'd0;  // s
      8'h77:   kw_idx   = 2'd1;  // w
      8'h70:   kw_idx   = 2'd2;  // p
      8'h64:   kw_idx   = 2'd3;  // d
      default: kw_start = 1'b0;
    endcase
    c_start = !(c_space || c_nul || op_hit || c_lp || c_rp);
    id_term = c_space || c_nul || c_lp || c_rp;
  end

  always_comb begin
    unique case (kw_choice)
      2'd0:    kw_kind = lts_pkg::TK_SETQ;
      2'd1:    kw_kind = lts_pkg::TK_WHILE;
      2'd2:    kw_kind = lts_pkg::TK_PRINT;
      default: kw_kind = lts_pkg::TK_DEFUN;
    endcase
  end

  assign kw_hit  = (match_pos < lts_pkg::kw_len(kw_choice)) &&
                   (c == lts_pkg::kw_char(kw_choice, match_pos));
  assign kw_done = kw_hit && (3'(match_pos + 3'd1) >= lts_pkg::kw_len(kw_choice));

  // mode a fresh character starts from idle
  always_comb begin
    if (!c_start) begin
      idle_mode = lts_pkg::MODE_IDLE;
    end else if (c_digit) begin
      idle_mode = lts_pkg::MODE_NUMBER;
    end else if (kw_start) begin
      idle_mode = lts_pkg::MODE_KEYWORD;
    end else begin
      idle_mode = lts_pkg::MODE_IDENT;
    end
  end

  // the character is scanned as if idle (possibly after closing a token)
  always_comb begin
    unique case (mode)
      lts_pkg::MODE_NUMBER:  rescan = !c_digit;
      lts_pkg::MODE_KEYWORD: rescan = !kw_hit && id_term;
      lts_pkg::MODE_IDENT:   rescan = id_term;
      lts_pkg::MODE_IDLE:    rescan = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    mode_next = mode;
    unique case (mode)
      lts_pkg::MODE_NUMBER: begin
        if (!c_digit) mode_next = idle_mode;
      end
      lts_pkg::MODE_KEYWORD: begin
        if (kw_hit) begin
          if (kw_done) mode_next = lts_pkg::MODE_IDLE;
        end else begin
          mode_next = id_term ? idle_mode : lts_pkg::MODE_IDENT;
        end
      end
      lts_pkg::MODE_IDENT: begin
        if (id_term) mode_next = idle_mode;
      end
      lts_pkg::MODE_IDLE: begin
        mode_next = idle_mode;
      end
    endcase
  end

  // token outputs
  always_comb begin
    pre_v   = 1'b0;
    pre_tok = '0;
    pre_tok.line = 16'(tok_line);
    pre_tok.col  = 16'(tok_col);
    unique case (mode)
      lts_pkg::MODE_NUMBER: begin
        if (!c_digit) begin
          pre_v         = 1'b1;
          pre_tok.kind  = lts_pkg::TK_NUMBER;
          pre_tok.value = 32'(accum);
          pre_tok.ovf   = sat;
        end
      end
      lts_pkg::MODE_KEYWORD: begin
        if (kw_done) begin
          pre_v        = 1'b1;
          pre_tok.kind = kw_kind;
        end else if (!kw_hit && id_term) begin
          pre_v          = 1'b1;
          pre_tok.kind   = lts_pkg::TK_IDENT;
          pre_tok.len    = id_count;
          pre_tok.prefix = id_chars;
        end
      end
      lts_pkg::MODE_IDENT: begin
        if (id_term) begin
          pre_v          = 1'b1;
          pre_tok.kind   = lts_pkg::TK_IDENT;
          pre_tok.len    = id_count;
          pre_tok.prefix = id_chars;
        end
      end
      lts_pkg::MODE_IDLE: begin
        pre_v = 1'b0;
      end
    endcase

    idle_v   = rescan && !c_space && !c_start;
    idle_tok = '0;
    idle_tok.line = 16'(line_count);
    idle_tok.col  = 16'(col_count);
    idle_tok.last = 1'b1;
    if (c_nul) begin
      idle_tok.kind = lts_pkg::TK_END;
    end else if (c_lp) begin
      idle_tok.kind = lts_pkg::TK_LPAREN;
    end else if (c_rp) begin
      idle_tok.kind = lts_pkg::TK_RPAREN;
    end else begin
      idle_tok.kind = op_kind;
    end
    pre_tok.last = !idle_v;

    push.push0 = accept && (pre_v || idle_v);
    push.push1 = accept && pre_v && idle_v;
    push.tok0  = pre_v ? pre_tok : idle_tok;
    push.tok1  = idle_tok;
  end

  // datapath updates
  always_comb begin
    digit = 4'(c - lts_pkg::CH_ZERO);
    prod  = ((NUMBER_BITS+4)'(accum) << 3) + ((NUMBER_BITS+4)'(accum) << 1) +
            (NUMBER_BITS+4)'(digit);
    do_append = ((mode == lts_pkg::MODE_KEYWORD) && (kw_hit || !id_term)) ||
                ((mode == lts_pkg::MODE_IDENT) && !id_term);

    accum_next     = accum;
    sat_next       = sat;
    id_count_next  = id_count;
    id_chars_next  = id_chars;
    kw_choice_next = kw_choice;
    match_pos_next = match_pos;
    tok_line_next  = tok_line;
    tok_col_next   = tok_col;

    if (mode == lts_pkg::MODE_NUMBER && c_digit) begin
      if (sat || (|prod[NUMBER_BITS+3:NUMBER_BITS])) begin
        accum_next = NUM_MAX;
        sat_next   = 1'b1;
      end else begin
        accum_next = prod[NUMBER_BITS-1:0];
      end
    end

    if (do_append) begin
      for (int i = 0; i < 8; i++) begin
        if (id_count == 8'(i)) id_chars_next[i*8 +: 8] = id_chars[i*8 +: 8] | c;
      end
      if (id_count < 8'(IDENT_LIMIT)) id_count_next = 8'(id_count + 8'd1);
    end

    if (mode == lts_pkg::MODE_KEYWORD && kw_hit) match_pos_next = 3'(match_pos + 3'd1);

    if (rescan && c_start) begin
      tok_line_next = line_count;
      tok_col_next  = col_count;
      if (c_digit) begin
        accum_next = NUMBER_BITS'(digit);
        sat_next   = 1'b0;
      end else begin
        id_count_next = 8'd1;
        id_chars_next = 64'(c);
        if (kw_start) begin
          kw_choice_next = kw_idx;
          match_pos_next = 3'd1;
        end
      end
    end

    line_count_next = line_count;
    col_count_next  = col_count;
    if (c == lts_pkg::CH_NL) begin
      if (line_count < POS_MAX) line_count_next = line_count + POS_ONE;
      col_count_next = POS_ONE;
    end else if (col_count < POS_MAX) begin
      col_count_next = col_count + POS_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= lts_pkg::MODE_IDLE;
      kw_choice  <= 2'd0;
      match_pos  <= 3'd0;
      sat        <= 1'b0;
      id_count   <= 8'd0;
      line_count <= POS_ONE;
      col_count  <= POS_ONE;
    end else if (accept) begin
      mode       <= mode_next;
      kw_choice  <= kw_choice_next;
      match_pos  <= match_pos_next;
      sat        <= sat_next;
      id_count   <= id_count_next;
      line_count <= line_count_next;
      col_count  <= col_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      accum    <= accum_next;
      id_chars <= id_chars_next;
      tok_line <= tok_line_next;
      tok_col  <= tok_col_next;
    end
  end

`include "lisp_token_scanner_unit_macros.svh"

  `LTS_ASSERT_IMPLY(a_kw_pos, mode == lts_pkg::MODE_KEYWORD, match_pos >= 3'd1 && match_pos <= 3'd4, "keyword match position out of range")
  `LTS_ASSERT_IMPLY(a_push_order, push.push1, push.push0, "second token without first")

endmodule

@@ hw/rtl/lts_fifo.sv @@
// Token queue between scanner front end and output stage; takes up to two writes a cycle.
module lts_fifo (
  input  logic               clk,
  input  logic               rst,
  input  lts_pkg::push_req_t push,
  output logic               space_ok,
  output logic               head_valid,
  output lts_pkg::token_t    head,
  input  logic               pop
);

  localparam int DEPTH = lts_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  lts_pkg::token_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count, count_next;

  assign space_ok   = (count <= CW'(DEPTH - 2));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_comb begin
    count_next = count + CW'(push.push0) + CW'(push.push1) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push.push0) + PW'(push.push1);
      if (pop) rd_ptr <= rd_ptr + PW'(1);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push0) mem[wr_ptr] <= push.tok0;
    if (push.push1) mem[PW'(wr_ptr + PW'(1))] <= push.tok1;
  end

`include "lisp_token_scanner_unit_macros.svh"

  `LTS_ASSERT_CLK(a_count_max, count <= CW'(DEPTH), "queue count beyond depth")
  `LTS_ASSERT_IMPLY(a_push_space, push.push0, count <= CW'(DEPTH - 2), "write request without two free slots")
  `LTS_ASSERT_NEXT(a_pop_count, pop && !push.push0, count == $past(count) - CW'(1), "pop did not drop count")

endmodule

@@ hw/rtl/lts_back.sv @@
// Output stage: moves queued tokens into the result register toward the downstream port.
module lts_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  lts_pkg::token_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output lts_pkg::token_t out_tok
);

  assign pop = head_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_tok <= head;
  end

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for lisp_token_scanner_unit: character stream in, token stream checked.
`timescale 1ns / 1ps
module tb_top;

  localparam int RANDOM_ITEMS = 1900;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 16;
  localparam logic [15:0] POS_MAX = 16'hFFFF;
  localparam logic [31:0] NUM_MAX = 32'hFFFFFFFF;
  localparam logic [7:0]  LEN_MAX = 8'd255;
  localparam logic [7:0]  SYMBOLS [8] = '{lts_pkg::CH_PLUS, lts_pkg::CH_MINUS,
                                          lts_pkg::CH_STAR, lts_pkg::CH_SLASH,
                                          lts_pkg::CH_GT, lts_pkg::CH_LT,
                                          lts_pkg::CH_LPAR, lts_pkg::CH_RPAR};

  typedef struct {
    logic [7:0]         ch;
    bit                 typed;
    lts_pkg::tok_kind_t kind;
  } stim_row_t;

  logic                        clk;
  logic                        rst;
  logic                        s_axis_tvalid;
  logic                        s_axis_tready;
  logic [7:0]                  s_axis_tdata;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready;
  logic [lts_pkg::TDATA_W-1:0] m_axis_tdata;
  logic                        m_axis_tlast;

  // scanner shadow state
  lts_pkg::scan_mode_t sc_mode;
  logic [1:0]  sc_kw;
  logic [2:0]  sc_kw_pos;
  logic [31:0] sc_num;
  logic        sc_num_sat;
  logic [7:0]  sc_id_len;
  logic [63:0] sc_id_text;
  logic [15:0] sc_line;
  logic [15:0] sc_col;
  logic [15:0] sc_tok_line;
  logic [15:0] sc_tok_col;

  string           kw_word [4];
  lts_pkg::token_t char_tokens[$];
  lts_pkg::token_t tokens_due[$];
  logic [7:0]      frag[$];
  stim_row_t       directed_rows [22];
  bit              send_paced;
  bit              recv_paced;
  int              mismatches;
  int              quiet_cycles;
  int              counted_chars;

  lisp_token_scanner_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit is_blank(logic [7:0] c);
    return c == lts_pkg::CH_SP || c == lts_pkg::CH_TAB || c == lts_pkg::CH_BS ||
           c == lts_pkg::CH_NL;
  endfunction

  function automatic bit is_numeral(logic [7:0] c);
    return c >= lts_pkg::CH_ZERO && c < lts_pkg::CH_COLON;
  endfunction

  function automatic bit ends_ident(logic [7:0] c);
    return is_blank(c) || c == lts_pkg::CH_NUL || c == lts_pkg::CH_LPAR ||
           c == lts_pkg::CH_RPAR;
  endfunction

  function automatic bit is_symbol(logic [7:0] c);
    return c == lts_pkg::CH_PLUS || c == lts_pkg::CH_MINUS || c == lts_pkg::CH_STAR ||
           c == lts_pkg::CH_SLASH || c == lts_pkg::CH_GT || c == lts_pkg::CH_LT ||
           c == lts_pkg::CH_LPAR || c == lts_pkg::CH_RPAR;
  endfunction

  function automatic string token_text(lts_pkg::token_t t);
    return $sformatf("kind=%0d value=%h ovf=%b len=%0d prefix=%h line=%0d col=%0d last=%b",
                     t.kind, t.value, t.ovf, t.len, t.prefix, t.line, t.col, t.last);
  endfunction

  task automatic add_token(lts_pkg::tok_kind_t k, logic [31:0] v, logic o, logic [7:0] n,
                           logic [63:0] p, logic [15:0] ln, logic [15:0] co);
    lts_pkg::token_t t;
    if (char_tokens.size() < 2) begin
      t.kind   = k;
      t.value  = v;
      t.ovf    = o;
      t.len    = n;
      t.prefix = p;
      t.line   = ln;
      t.col    = co;
      t.last   = 1'b0;
      char_tokens.push_back(t);
    end
  endtask

  task automatic add_plain(lts_pkg::tok_kind_t k);
    add_token(k, '0, 1'b0, '0, '0, sc_line, sc_col);
  endtask

  task automatic ident_add(logic [7:0] c);
    if (sc_id_len < 8) sc_id_text |= 64'(c) << (sc_id_len * 8);
    if (sc_id_len < LEN_MAX) sc_id_len++;
  endtask

  task automatic scan_idle(logic [7:0] c);
    sc_mode = lts_pkg::MODE_IDLE;
    if (is_blank(c)) return;
    case (c)
      lts_pkg::CH_NUL:   add_plain(lts_pkg::TK_END);
      lts_pkg::CH_PLUS:  add_plain(lts_pkg::TK_ADD);
      lts_pkg::CH_MINUS: add_plain(lts_pkg::TK_SUB);
      lts_pkg::CH_STAR:  add_plain(lts_pkg::TK_MUL);
      lts_pkg::CH_SLASH: add_plain(lts_pkg::TK_DIV);
      lts_pkg::CH_GT:    add_plain(lts_pkg::TK_GREATER);
      lts_pkg::CH_LT:    add_plain(lts_pkg::TK_LESS);
      lts_pkg::CH_LPAR:  add_plain(lts_pkg::TK_LPAREN);
      lts_pkg::CH_RPAR:  add_plain(lts_pkg::TK_RPAREN);
      default: begin
        sc_tok_line = sc_line;
        sc_tok_col  = sc_col;
        if (is_numeral(c)) begin
          sc_mode    = lts_pkg::MODE_NUMBER;
          sc_num     = 32'(c - lts_pkg::CH_ZERO);
          sc_num_sat = 1'b0;
        end else begin
          sc_id_len  = 8'd1;
          sc_id_text = 64'(c);
          sc_mode    = lts_pkg::MODE_IDENT;
          for (int i = 0; i < 4; i++) begin
            if (c == kw_word[i][0]) begin
              sc_mode   = lts_pkg::MODE_KEYWORD;
              sc_kw     = 2'(i);
              sc_kw_pos = 3'd1;
            end
          end
        end
      end
    endcase
  endtask

  task automatic ident_char(logic [7:0] c);
    if (ends_ident(c)) begin
      add_token(lts_pkg::TK_IDENT, '0, 1'b0, sc_id_len, sc_id_text, sc_tok_line, sc_tok_col);
      scan_idle(c);
    end else begin
      ident_add(c);
    end
  endtask

  // Tokens caused by one character land in char_tokens.
  task automatic scan_char(logic [7:0] c);
    logic [31:0] d;
    int kw_n;
    char_tokens.delete();
    case (sc_mode)
      lts_pkg::MODE_NUMBER: begin
        if (is_numeral(c)) begin
          d = 32'(c - lts_pkg::CH_ZERO);
          if (sc_num_sat || sc_num > (NUM_MAX - d) / 10) begin
            sc_num     = NUM_MAX;
            sc_num_sat = 1'b1;
          end else begin
            sc_num = sc_num * 10 + d;
          end
        end else begin
          add_token(lts_pkg::TK_NUMBER, sc_num, sc_num_sat, '0, '0, sc_tok_line, sc_tok_col);
          scan_idle(c);
        end
      end
      lts_pkg::MODE_KEYWORD: begin
        kw_n = kw_word[sc_kw].len();
        if (sc_kw_pos < kw_n && c == kw_word[sc_kw][sc_kw_pos]) begin
          ident_add(c);
          sc_kw_pos++;
          if (sc_kw_pos >= kw_n) begin
            add_token(lts_pkg::tok_kind_t'(lts_pkg::TK_SETQ + sc_kw), '0, 1'b0, '0, '0,
                      sc_tok_line, sc_tok_col);
            sc_mode = lts_pkg::MODE_IDLE;
          end
        end else begin
          // broken keyword prefix carries on as an identifier
          sc_mode = lts_pkg::MODE_IDENT;
          ident_char(c);
        end
      end
      lts_pkg::MODE_IDENT: ident_char(c);
      default:             scan_idle(c);
    endcase
    if (c == lts_pkg::CH_NL) begin
      if (sc_line < POS_MAX) sc_line++;
      sc_col = 16'd1;
    end else if (sc_col < POS_MAX) begin
      sc_col++;
    end
    if (char_tokens.size() > 0) char_tokens[char_tokens.size() - 1].last = 1'b1;
  endtask

  task automatic send_char(logic [7:0] c, bit model_result);
    int gap;
    gap = send_paced ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    scan_char(c);
    if (model_result) begin
      foreach (char_tokens[i]) tokens_due.push_back(char_tokens[i]);
    end
    counted_chars++;
  endtask

  function automatic logic [7:0] rand_letter();
    return 8'($urandom_range("a", "z"));
  endfunction

  function automatic logic [7:0] rand_ident_char();
    logic [7:0] c;
    if ($urandom_range(0, 9) < 8) return rand_letter();
    c = 8'($urandom_range(0, 255));
    while (ends_ident(c)) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] rand_ident_start();
    logic [7:0] c;
    if ($urandom_range(0, 9) < 7) return rand_letter();
    c = 8'($urandom_range(0, 255));
    while (ends_ident(c) || is_numeral(c) || is_symbol(c)) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 3))
      0:       return lts_pkg::CH_SP;
      1:       return lts_pkg::CH_TAB;
      2:       return lts_pkg::CH_BS;
      default: return lts_pkg::CH_NL;
    endcase
  endfunction

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) frag.push_back(s[i]);
  endtask

  // One lexical fragment with random content, mostly well formed.
  task automatic build_fragment();
    int pick;
    int n;
    int sel;
    int r;
    logic [7:0] c;
    bit word;
    frag.delete();
    word = 1'b1;
    pick = $urandom_range(0, 99);
    sel  = $urandom_range(0, 3);
    if (pick < 20) begin
      push_text(kw_word[sel]);
      // keyword glued to the following letter: no delimiter check
      if ($urandom_range(0, 5) == 0) frag.push_back(rand_letter());
    end else if (pick < 30) begin
      n = $urandom_range(1, kw_word[sel].len() - 1);
      for (int i = 0; i < n; i++) frag.push_back(kw_word[sel][i]);
      c = rand_ident_char();
      if (c == kw_word[sel][n]) c = "x";
      frag.push_back(c);
      repeat ($urandom_range(0, 3)) frag.push_back(rand_ident_char());
    end else if (pick < 50) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        push_text("4294967295");
      end else if (r == 1) begin
        push_text("4294967296");
      end else begin
        n = (r < 4) ? $urandom_range(9, 14) : $urandom_range(1, 6);
        repeat (n) frag.push_back(8'($urandom_range(lts_pkg::CH_ZERO, lts_pkg::CH_ZERO + 9)));
      end
    end else if (pick < 65) begin
      n = ($urandom_range(0, 49) == 0) ? $urandom_range(250, 300) : $urandom_range(1, 10);
      frag.push_back(rand_ident_start());
      repeat (n - 1) frag.push_back(rand_ident_char());
    end else begin
      word = 1'b0;
      if (pick < 80) frag.push_back(SYMBOLS[$urandom_range(0, 7)]);
      else if (pick < 88) repeat ($urandom_range(1, 3)) frag.push_back(rand_blank());
      else if (pick < 92) frag.push_back(lts_pkg::CH_NUL);
      else repeat ($urandom_range(1, 3)) frag.push_back(8'($urandom_range(0, 255)));
    end
    if (word) begin
      r = $urandom_range(0, 19);
      if (r < 12) frag.push_back(rand_blank());
      else if (r < 15)
        frag.push_back(($urandom_range(0, 1) != 0) ? lts_pkg::CH_LPAR : lts_pkg::CH_RPAR);
      else if (r < 17) frag.push_back(lts_pkg::CH_NUL);
    end
  endtask

  task automatic check_token(logic [lts_pkg::TDATA_W-1:0] d, logic l);
    lts_pkg::token_t got;
    lts_pkg::token_t want;
    // tdata: kind, value, overflow, length, prefix, line, column from bit 0 up
    got.kind   = lts_pkg::tok_kind_t'(d[3:0]);
    got.value  = d[35:4];
    got.ovf    = d[36];
    got.len    = d[44:37];
    got.prefix = d[108:45];
    got.line   = d[124:109];
    got.col    = d[140:125];
    got.last   = l;
    if (tokens_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected token: %s", token_text(got));
    end else begin
      want = tokens_due.pop_front();
      if (got.kind !== want.kind || got.value !== want.value || got.ovf !== want.ovf ||
          got.len !== want.len || got.prefix !== want.prefix || got.line !== want.line ||
          got.col !== want.col || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("token mismatch\n  expected %s\n  actual   %s",
                   token_text(want), token_text(got));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("lisp_token_scanner_unit: mismatch");
      $finish;
    end
  end

  initial begin : token_sink
    int stall;
    m_axis_tready = 1'b0;
    recv_paced    = 1'b1;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) recv_paced = !recv_paced;
      stall = recv_paced ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      check_token(m_axis_tdata, m_axis_tlast);
    end
  end

  initial begin : char_source
    lts_pkg::token_t typed_tok;
    bit held;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    counted_chars = 0;
    send_paced    = 1'b1;
    held          = 1'b0;
    kw_word       = '{"setq", "while", "print", "defun"};
    sc_mode       = lts_pkg::MODE_IDLE;
    sc_kw         = '0;
    sc_kw_pos     = '0;
    sc_num        = '0;
    sc_num_sat    = 1'b0;
    sc_id_len     = '0;
    sc_id_text    = '0;
    sc_line       = 16'd1;
    sc_col        = 16'd1;
    sc_tok_line   = 16'd1;
    sc_tok_col    = 16'd1;
    directed_rows = '{
      '{lts_pkg::CH_PLUS,  1'b1, lts_pkg::TK_ADD},
      '{lts_pkg::CH_MINUS, 1'b1, lts_pkg::TK_SUB},
      '{lts_pkg::CH_STAR,  1'b1, lts_pkg::TK_MUL},
      '{lts_pkg::CH_SLASH, 1'b1, lts_pkg::TK_DIV},
      '{lts_pkg::CH_GT,    1'b1, lts_pkg::TK_GREATER},
      '{lts_pkg::CH_LT,    1'b1, lts_pkg::TK_LESS},
      '{lts_pkg::CH_LPAR,  1'b1, lts_pkg::TK_LPAREN},
      '{lts_pkg::CH_RPAR,  1'b1, lts_pkg::TK_RPAREN},
      '{lts_pkg::CH_NUL,   1'b1, lts_pkg::TK_END},
      '{"s", 1'b0, lts_pkg::TK_END}, '{"e", 1'b0, lts_pkg::TK_END},
      '{"t", 1'b0, lts_pkg::TK_END}, '{"q", 1'b0, lts_pkg::TK_END},
      '{"p", 1'b0, lts_pkg::TK_END}, '{"r", 1'b0, lts_pkg::TK_END},
      '{lts_pkg::CH_RPAR, 1'b0, lts_pkg::TK_END},
      '{"7", 1'b0, lts_pkg::TK_END}, '{"x", 1'b0, lts_pkg::TK_END},
      '{lts_pkg::CH_NL, 1'b0, lts_pkg::TK_END},
      '{"9", 1'b0, lts_pkg::TK_END},
      '{lts_pkg::CH_NUL, 1'b0, lts_pkg::TK_END},
      '{lts_pkg::CH_BS, 1'b0, lts_pkg::TK_END}
    };
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // single-character tokens right after reset sit on line 1, one column each
    foreach (directed_rows[r]) begin
      send_char(directed_rows[r].ch, !directed_rows[r].typed);
      if (directed_rows[r].typed) begin
        typed_tok        = '0;
        typed_tok.kind   = directed_rows[r].kind;
        typed_tok.line   = 16'd1;
        typed_tok.col    = 16'(r + 1);
        typed_tok.last   = 1'b1;
        tokens_due.push_back(typed_tok);
      end
    end

    counted_chars = 0;
    while (counted_chars < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) send_paced = !send_paced;
      build_fragment();
      foreach (frag[i]) send_char(frag[i], 1'b1);
      if (!held && counted_chars >= RANDOM_ITEMS / 2) begin
        // hold off until every outstanding request has drained
        held = 1'b1;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (tokens_due.size() != 0) @(posedge clk);
      end
    end

    // short mixed tail ending in end of text
    send_paced = 1'b1;
    frag.delete();
    push_text("+ab 7(");
    foreach (frag[i]) send_char(frag[i], 1'b1);
    frag.delete();
    push_text("setq(12 x");
    frag.push_back(lts_pkg::CH_NUL);
    foreach (frag[i]) send_char(frag[i], 1'b1);

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("lisp_token_scanner_unit: match");
    else
      $display("lisp_token_scanner_unit: mismatch");
    $finish;
  end

endmodule
